// ===== design/sha1bsh_pkg.sv =====
`default_nettype none
package sha1bsh_pkg;

   // request codes
   localparam logic [1:0] REQ_ABSORB   = 2'd0;
   localparam logic [1:0] REQ_FINALIZE = 2'd1;
   localparam logic [1:0] REQ_RESTART  = 2'd2;

   // five hash words, index 0 is h0 (or a)
   typedef logic [4:0][31:0] hash_type;

   localparam hash_type HASH_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                     32'hEFCDAB89, 32'h67452301};

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   localparam logic [6:0] ROUND_GROUP1 = 7'd20;
   localparam logic [6:0] ROUND_GROUP2 = 7'd40;
   localparam logic [6:0] ROUND_GROUP3 = 7'd60;
   localparam logic [6:0] ROUND_LAST   = 7'd79;

   localparam logic [7:0] PAD_MARK    = 8'h80;
   localparam logic [5:0] PAD_LEN_POS = 6'd56;
   localparam logic [5:0] FILL_LAST   = 6'd63;

   typedef struct packed {
      logic       shift_byte;
      logic       shift_word;
      logic [7:0] data_byte;
   } sched_ctrl_type;

   typedef struct packed {
      logic load;
      logic step;
   } round_ctrl_type;

endpackage
`default_nettype wire

// ===== design/sha1bsh_sched.sv =====
`default_nettype none
module sha1bsh_sched
   import sha1bsh_pkg::*;
(
   input  wire logic           clock,
   input  wire sched_ctrl_type ctrl,
   output logic [31:0]         w_word
);

   // 16-word shift line, oldest word at the top
   logic [511:0] buf_ff;
   logic [511:0] buf_in;
   logic [31:0]  mix;

   always_comb begin
      mix    = buf_ff[511:480] ^ buf_ff[447:416] ^ buf_ff[255:224] ^ buf_ff[95:64];
      buf_in = buf_ff;
      if (ctrl.shift_byte) begin
         buf_in = {buf_ff[503:0], ctrl.data_byte};
      end else if (ctrl.shift_word) begin
         buf_in = {buf_ff[479:0], mix[30:0], mix[31]};
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign w_word = buf_ff[511:480];

endmodule
`default_nettype wire

// ===== design/sha1bsh_round.sv =====
`default_nettype none
module sha1bsh_round
   import sha1bsh_pkg::*;
(
   input  wire logic           clock,
   input  wire round_ctrl_type ctrl,
   input  wire logic [6:0]     round_idx,
   input  wire logic [31:0]    w_word,
   input  wire hash_type       hash,
   output hash_type            work
);

   hash_type    work_ff;
   hash_type    work_in;
   logic [31:0] a, b, c, d, e;
   logic [31:0] f, k, t;

   always_comb begin
      a = work_ff[0];
      b = work_ff[1];
      c = work_ff[2];
      d = work_ff[3];
      e = work_ff[4];
      if (round_idx < ROUND_GROUP1) begin
         f = (b & c) | (~b & d);
         k = K_ROUND0;
      end else if (round_idx < ROUND_GROUP2) begin
         f = b ^ c ^ d;
         k = K_ROUND1;
      end else if (round_idx < ROUND_GROUP3) begin
         f = (b & c) | (b & d) | (c & d);
         k = K_ROUND2;
      end else begin
         f = b ^ c ^ d;
         k = K_ROUND3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w_word;
      work_in[0] = t;
      work_in[1] = a;
      work_in[2] = {b[1:0], b[31:2]};
      work_in[3] = c;
      work_in[4] = d;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         work_ff <= hash;
      end else if (ctrl.step) begin
         work_ff <= work_in;
      end
   end

   assign work = work_ff;

endmodule
`default_nettype wire

// ===== design/sha1_byte_stream_hasher.sv =====
// sha-1 hasher over a byte stream
//
// request channel (req_valid / req_stall): req_type selects absorb byte,
// finalize or restart; req_byte_value carries the message byte on absorb.
// req_stall is high whenever the sequencer is busy, one request at a time.
// an absorb is taken in idle; the 64th byte of a block starts the compression,
// which runs one round per cycle on a single shared round unit: 80 rounds,
// then an update state folds the result into the hash.
// finalize shifts the padding in one byte per cycle (0x80, zeros, then the
// 64-bit length) and compresses the block; the padding runs on into a second
// block when the length no longer fits in the current block.
// the five digest words then go out on the response channel (rsp_valid /
// rsp_stall), h0 first, rsp_last_word on the fifth; a stalled word is held.
// a finalize after a finalize re-sends the stored digest right away.
// bytes after finalize are dropped; restart brings back the initial hash.
// reset returns the block to the initial hash with empty counts.
`default_nettype none
module sha1_byte_stream_hasher
   import sha1bsh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [7:0]  req_byte_value,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word
);

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_ROUND  = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_PAD    = 5'b01000,
      ST_EMIT   = 5'b10000
   } state_type;

   state_type      state_ff, state_in;
   hash_type       hash_ff, hash_in;
   logic [5:0]     fill_ff, fill_in;
   logic [60:0]    total_ff, total_in;
   logic           finished_ff, finished_in;
   logic           pad_ff, pad_in;       // padding in progress
   logic           len_ok_ff, len_ok_in; // this block takes the length field
   logic [6:0]     round_ff, round_in;
   logic [2:0]     widx_ff, widx_in;

   sched_ctrl_type sched_ctrl;
   round_ctrl_type round_ctrl;
   logic [31:0]    w_word;
   hash_type       work;

   logic           push;
   logic [7:0]     push_val;
   logic [63:0]    len_shift;

   sha1bsh_sched u_sched (
      .clock  (clock),
      .ctrl   (sched_ctrl),
      .w_word (w_word)
   );

   sha1bsh_round u_round (
      .clock     (clock),
      .ctrl      (round_ctrl),
      .round_idx (round_ff),
      .w_word    (w_word),
      .hash      (hash_ff),
      .work      (work)
   );

   // big-endian length byte for the current buffer position
   assign len_shift = {total_ff, 3'b000} << {fill_ff[2:0], 3'b000};

   always_comb begin
      state_in    = state_ff;
      hash_in     = hash_ff;
      fill_in     = fill_ff;
      total_in    = total_ff;
      finished_in = finished_ff;
      pad_in      = pad_ff;
      len_ok_in   = len_ok_ff;
      round_in    = round_ff;
      widx_in     = widx_ff;
      push        = 1'b0;
      push_val    = 8'h00;
      round_ctrl  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_type == REQ_ABSORB) begin
                  if (!finished_ff) begin
                     push     = 1'b1;
                     push_val = req_byte_value;
                     total_in = total_ff + 61'd1;
                  end
               end else if (req_type == REQ_FINALIZE) begin
                  if (finished_ff) begin
                     widx_in  = 3'd0;
                     state_in = ST_EMIT;
                  end else begin
                     push      = 1'b1;
                     push_val  = PAD_MARK;
                     pad_in    = 1'b1;
                     len_ok_in = (fill_ff < PAD_LEN_POS);
                     state_in  = ST_PAD;
                  end
               end else if (req_type == REQ_RESTART) begin
                  hash_in     = HASH_INIT;
                  fill_in     = 6'd0;
                  total_in    = 61'd0;
                  finished_in = 1'b0;
               end
            end
         end
         ST_PAD: begin
            push = 1'b1;
            if (len_ok_ff && (fill_ff >= PAD_LEN_POS)) begin
               push_val = len_shift[63:56];
            end
         end
         ST_ROUND: begin
            round_ctrl.step = 1'b1;
            round_in        = round_ff + 7'd1;
            if (round_ff == ROUND_LAST) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            for (int i = 0; i < 5; i++) begin
               hash_in[i] = hash_ff[i] + work[i];
            end
            if (pad_ff) begin
               if (len_ok_ff) begin
                  finished_in = 1'b1;
                  pad_in      = 1'b0;
                  widx_in     = 3'd0;
                  state_in    = ST_EMIT;
               end else begin
                  len_ok_in = 1'b1;
                  state_in  = ST_PAD;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               widx_in = widx_ff + 3'd1;
               if (widx_ff == 3'd4) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a byte into the buffer; the 64th one starts the compression
      if (push) begin
         fill_in = fill_ff + 6'd1;
         if (fill_ff == FILL_LAST) begin
            round_ctrl.load = 1'b1;
            round_in        = 7'd0;
            state_in        = ST_ROUND;
         end
      end

      sched_ctrl.shift_byte = push;
      sched_ctrl.shift_word = round_ctrl.step;
      sched_ctrl.data_byte  = push_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         hash_ff     <= HASH_INIT;
         fill_ff     <= 6'd0;
         total_ff    <= 61'd0;
         finished_ff <= 1'b0;
         pad_ff      <= 1'b0;
         len_ok_ff   <= 1'b0;
         round_ff    <= 7'd0;
         widx_ff     <= 3'd0;
      end else begin
         state_ff    <= state_in;
         hash_ff     <= hash_in;
         fill_ff     <= fill_in;
         total_ff    <= total_in;
         finished_ff <= finished_in;
         pad_ff      <= pad_in;
         len_ok_ff   <= len_ok_in;
         round_ff    <= round_in;
         widx_ff     <= widx_in;
      end
   end

   // handshake and digest output
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_word = hash_ff[widx_ff];
   assign rsp_word_index  = widx_ff;
   assign rsp_last_word   = (widx_ff == 3'd4);

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import sha1bsh_pkg::*;

   // request code the block must drop without a trace
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // round constants of sha-1
   localparam logic [31:0] K_00_19 = 32'h5A827999;
   localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
   localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
   localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

   // cycles with no request and no digest word accepted before giving up
   localparam int STALL_LIMIT = 4000;
   // settle time after the last digest word
   localparam int DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } hash_request_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        is_last;
   } digest_word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = REQ_ABSORB;
   logic [7:0]  req_byte_value = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha1_byte_stream_hasher u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_byte_value  (req_byte_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   // requests waiting for the driver, digest words waiting for the block
   hash_request_type pending_requests[$];
   digest_word_type  expected_words[$];

   // idling of both channels, percent of cycles, set per phase
   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;

   int fail_count = 0;
   int idle_cycles = 0;

   // stimulus bookkeeping per phase
   int phase_items;
   int phase_closes;

   // ---------------------------------------------------------------
   // sha-1 predictor state
   // ---------------------------------------------------------------
   logic [31:0] digest_state [0:4];
   logic [7:0]  block_bytes [0:63];
   int          block_fill;
   logic [60:0] message_bytes;   // bit length is this times 8, wraps mod 2^64
   logic        digest_closed;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // one 64-byte block through the 80 rounds
   task automatic sha1_compress_block();
      logic [31:0] w [0:79];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 80; i++)
         w[i] = rotl32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = digest_state[0];
      b = digest_state[1];
      c = digest_state[2];
      d = digest_state[3];
      e = digest_state[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = K_00_19;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = K_20_39;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_40_59;
         end else begin
            f = b ^ c ^ d;
            k = K_60_79;
         end
         t = rotl32(a, 5) + f + e + k + w[i];
         e = d;
         d = c;
         c = rotl32(b, 30);
         b = a;
         a = t;
      end
      digest_state[0] += a;
      digest_state[1] += b;
      digest_state[2] += c;
      digest_state[3] += d;
      digest_state[4] += e;
   endtask

   // back to the initial hash, buffer contents stay
   task automatic sha1_restart();
      digest_state[0] = 32'h67452301;
      digest_state[1] = 32'hEFCDAB89;
      digest_state[2] = 32'h98BADCFE;
      digest_state[3] = 32'h10325476;
      digest_state[4] = 32'hC3D2E1F0;
      block_fill = 0;
      message_bytes = '0;
      digest_closed = 1'b0;
   endtask

   // padding: marker byte, zeros, 64-bit length; one or two blocks
   task automatic sha1_close_message();
      logic [63:0] bit_len;
      int pos;
      bit_len = {message_bytes, 3'b000};
      pos = block_fill;
      block_bytes[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
         // length no longer fits, spill into a second block
         while (pos < 64) begin
            block_bytes[pos] = 8'h00;
            pos++;
         end
         sha1_compress_block();
         pos = 0;
      end
      while (pos < 56) begin
         block_bytes[pos] = 8'h00;
         pos++;
      end
      for (int i = 0; i < 8; i++)
         block_bytes[56+i] = bit_len[63-8*i -: 8];
      sha1_compress_block();
      block_fill = 0;
      digest_closed = 1'b1;
   endtask

   // apply one accepted request, queue the digest words it causes
   task automatic predict_request(input logic [1:0] kind, input logic [7:0] data);
      digest_word_type dw;
      case (kind)
         REQ_ABSORB: begin
            // bytes after finalize are dropped
            if (!digest_closed) begin
               block_bytes[block_fill] = data;
               message_bytes = message_bytes + 1'b1;
               block_fill++;
               if (block_fill == 64) begin
                  sha1_compress_block();
                  block_fill = 0;
               end
            end
         end
         REQ_FINALIZE: begin
            // a repeated finalize only re-sends the stored digest
            if (!digest_closed)
               sha1_close_message();
            for (int i = 0; i < 5; i++) begin
               dw.word = digest_state[i];
               dw.index = 3'(i);
               dw.is_last = (i == 4);
               expected_words.push_back(dw);
            end
         end
         REQ_RESTART: sha1_restart();
         default: ;   // unused code, no effect
      endcase
   endtask

   // ---------------------------------------------------------------
   // clock
   // ---------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // request driver: valid is raised once the last request has gone in,
   // and held with a steady payload while stalled
   // ---------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      hash_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         // the request on the bus went in at this edge
         if (req_valid)
            predict_request(req_type, req_byte_value);
         if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_req = pending_requests.pop_front();
            req_valid <= 1'b1;
            req_type <= next_req.kind;
            req_byte_value <= next_req.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // digest monitor: random back-pressure, in-order field check
   // ---------------------------------------------------------------
   always @(posedge clock) begin : check_digest
      digest_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected digest word: expected none, got %h index %0d last %b",
                        $time, rsp_digest_word, rsp_word_index, rsp_last_word);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_digest_word !== want.word) begin
                  $display("%0t: digest word %0d: expected %h, got %h",
                           $time, want.index, want.word, rsp_digest_word);
                  fail_count++;
               end
               if (rsp_word_index !== want.index) begin
                  $display("%0t: word index: expected %0d, got %0d",
                           $time, want.index, rsp_word_index);
                  fail_count++;
               end
               if (rsp_last_word !== want.is_last) begin
                  $display("%0t: last word flag at index %0d: expected %b, got %b",
                           $time, want.index, want.is_last, rsp_last_word);
                  fail_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // watchdog: too long with no handshake on either channel
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   task automatic push_request(input logic [1:0] kind, input logic [7:0] data,
                               input bit counted);
      hash_request_type r;
      r.kind = kind;
      r.data = data;
      pending_requests.push_back(r);
      if (counted)
         phase_items++;
   endtask

   // one message: restart, bytes with sparse noise, finalize unless abandoned,
   // then sometimes a repeat finalize, bytes that must be dropped or an unused code
   task automatic add_random_message();
      int len;
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) begin
         len = $urandom_range(20);
      end else if (pick < 80) begin
         // lengths around the padding and block edges
         case ($urandom_range(7))
            0: len = 55;
            1: len = 56;
            2: len = 57;
            3: len = 63;
            4: len = 64;
            5: len = 65;
            6: len = 119;
            default: len = 120;
         endcase
      end else begin
         len = $urandom_range(140);
      end
      push_request(REQ_RESTART, 8'($urandom_range(255)), 1'b1);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 3)
            push_request(REQ_UNUSED, 8'($urandom_range(255)), 1'b0);
         push_request(REQ_ABSORB, 8'($urandom_range(255)), 1'b1);
      end
      // abandoned message, the next restart throws it away
      if ($urandom_range(99) < 10)
         return;
      push_request(REQ_FINALIZE, 8'($urandom_range(255)), 1'b1);
      phase_closes++;
      if ($urandom_range(99) < 35)
         push_request(REQ_FINALIZE, 8'($urandom_range(255)), 1'b1);
      if ($urandom_range(99) < 35)
         repeat ($urandom_range(1, 3))
            push_request(REQ_ABSORB, 8'($urandom_range(255)), 1'b0);
      if ($urandom_range(99) < 15)
         push_request(REQ_UNUSED, 8'($urandom_range(255)), 1'b0);
   endtask

   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || req_valid || expected_words.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct);
      sender_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      phase_items = 0;
      phase_closes = 0;
      while (phase_items < 70 || phase_closes < 3)
         add_random_message();
      wait_for_drain();
   endtask

   initial begin
      sha1_restart();
      for (int i = 0; i < 64; i++)
         block_bytes[i] = 8'h00;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty message, repeat finalize, dropped byte, "abc",
      // unused code inside and after a message, extreme byte values
      push_request(REQ_FINALIZE, 8'h00, 1'b1);
      push_request(REQ_FINALIZE, 8'hFF, 1'b1);
      push_request(REQ_ABSORB, 8'hFF, 1'b0);
      push_request(REQ_RESTART, 8'hFF, 1'b1);
      push_request(REQ_ABSORB, 8'h61, 1'b1);
      push_request(REQ_ABSORB, 8'h62, 1'b1);
      push_request(REQ_UNUSED, 8'hA5, 1'b0);
      push_request(REQ_ABSORB, 8'h63, 1'b1);
      push_request(REQ_FINALIZE, 8'h5A, 1'b1);
      push_request(REQ_RESTART, 8'h00, 1'b1);
      push_request(REQ_ABSORB, 8'h00, 1'b1);
      push_request(REQ_ABSORB, 8'hFF, 1'b1);
      push_request(REQ_ABSORB, 8'h80, 1'b1);
      push_request(REQ_FINALIZE, 8'h00, 1'b1);
      push_request(REQ_FINALIZE, 8'h00, 1'b1);
      push_request(REQ_UNUSED, 8'h5A, 1'b0);
      push_request(REQ_ABSORB, 8'h00, 1'b0);
      push_request(REQ_RESTART, 8'h3C, 1'b1);
      push_request(REQ_FINALIZE, 8'hC3, 1'b1);
      wait_for_drain();

      // random messages under each idling pattern
      run_phase(0, 0);
      run_phase(45, 0);
      run_phase(0, 45);
      run_phase(23, 23);

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/sha1bsh_pkg.sv
design/sha1bsh_sched.sv
design/sha1bsh_round.sv
design/sha1_byte_stream_hasher.sv
sim/tb.sv
